>>> src/blfa_pkg.sv
package blfa_pkg;

    localparam int WORD_BITS = 64;
    localparam int IDX_W     = 12;
    localparam int CFG_W     = 13;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int BIT_W     = 6;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_TEST    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_OOR  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

    typedef struct packed {
        logic accept;
        logic rd;
        logic exec;
    } t_cmd;

endpackage

>>> src/blfa_ctrl.sv
module blfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output blfa_pkg::t_cmd o_cmd
);
    import blfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_exec;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign w_exec = (r_state == S_EXEC) && (!r_out_valid || m_axis_tready);

    assign o_cmd.accept = s_axis_tvalid && s_axis_tready;
    assign o_cmd.rd     = (r_state == S_READ);
    assign o_cmd.exec   = w_exec;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_exec) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (m_axis_tready) n_out_valid = 1'b0;
        if (w_exec)        n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> o_cmd.rd)
        else $error("accepted item did not start a word read");
    a_read_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd |=> (r_state == S_EXEC))
        else $error("word read not followed by execute");
    a_exec_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (m_axis_tvalid && !s_axis_tready == 1'b0 || m_axis_tvalid))
        else $error("execute did not present a result");
`endif

endmodule

>>> src/blfa_dpath.sv
module blfa_dpath #(
    parameter int ENTRIES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  blfa_pkg::t_cmd                i_cmd,
    input  logic                          i_cfg_we,
    input  logic [blfa_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [blfa_pkg::OP_W-1:0]     i_op,
    input  logic [blfa_pkg::IDX_W-1:0]    i_index,
    output logic [blfa_pkg::STAT_W-1:0]   o_status,
    output logic [blfa_pkg::IDX_W-1:0]    o_result_index,
    output logic                          o_was_used
);
    import blfa_pkg::*;

    localparam int WORD_COUNT = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int NW         = (WORD_COUNT < 64) ? WORD_COUNT : 64;
    localparam int AW         = (NW > 1) ? $clog2(NW) : 1;
    localparam logic [CFG_W-1:0] CAP_MAX = CFG_W'((ENTRIES < 4096) ? ENTRIES : 4096);

    logic [WORD_BITS-1:0] r_mem [NW];
    logic [NW-1:0]        r_wvalid;
    logic [NW-1:0]        r_full;
    logic [CFG_W-1:0]     r_cfg;
    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_idx;
    logic [AW-1:0]        r_waddr;
    logic                 r_found;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_valid;
    logic [STAT_W-1:0]    r_out_status;
    logic [IDX_W-1:0]     r_out_index;
    logic                 r_out_was;

    logic [CFG_W-1:0]     w_cap;
    logic [AW-1:0]        w_free_word;
    logic                 w_any_free;
    logic [AW-1:0]        w_rd_addr;
    logic [WORD_BITS-1:0] w_word;
    logic [BIT_W-1:0]     w_low_zero;
    logic [BIT_W-1:0]     w_bit;
    logic [IDX_W-1:0]     w_pos;
    logic                 w_in_range;
    logic [WORD_BITS-1:0] w_mask;
    logic [WORD_BITS-1:0] w_new_word;
    logic                 w_we;
    logic                 w_alloc;

    assign w_cap   = (r_cfg < CAP_MAX) ? r_cfg : CAP_MAX;
    assign w_alloc = (r_op == OP_ALLOC);

    always_comb begin
        w_free_word = '0;
        w_any_free  = 1'b0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                w_free_word = AW'(i);
                w_any_free  = 1'b1;
            end
        end
    end

    assign w_rd_addr = w_alloc ? w_free_word : r_idx[BIT_W +: AW];

    assign w_word = r_rd_valid ? r_rd_data : '0;

    always_comb begin
        w_low_zero = BIT_W'(WORD_BITS - 1);
        for (int b = WORD_BITS - 2; b >= 0; b--) begin
            if (!w_word[b]) w_low_zero = BIT_W'(b);
        end
    end

    assign w_bit  = w_alloc ? w_low_zero : r_idx[BIT_W-1:0];
    assign w_pos  = {BIT_W'(r_waddr), w_bit};
    assign w_mask = WORD_BITS'(1) << w_bit;
    assign w_in_range = w_alloc ? (r_found && ({1'b0, w_pos} < w_cap))
                                : ({1'b0, r_idx} < w_cap);

    always_comb begin
        case (r_op)
            OP_ALLOC:   w_new_word = w_word | w_mask;
            OP_MARK:    w_new_word = w_word | w_mask;
            OP_RELEASE: w_new_word = w_word & ~w_mask;
            default:    w_new_word = w_word;
        endcase
    end

    assign w_we = i_cmd.exec && w_in_range && (r_op != OP_TEST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_RESET;
            r_wvalid <= '0;
            r_full   <= '0;
        end else begin
            if (i_cfg_we) r_cfg <= i_cfg_wdata;
            if (w_we) begin
                r_wvalid[r_waddr] <= 1'b1;
                r_full[r_waddr]   <= &w_new_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[r_waddr] <= w_new_word;
        if (i_cmd.rd) begin
            r_rd_data  <= r_mem[w_rd_addr];
            r_rd_valid <= r_wvalid[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_op;
            r_idx <= i_index;
        end
        if (i_cmd.rd) begin
            r_waddr <= w_rd_addr;
            r_found <= w_alloc ? w_any_free : 1'b1;
        end
        if (i_cmd.exec) begin
            if (w_alloc) begin
                r_out_status <= w_in_range ? ST_OK : ST_FULL;
                r_out_index  <= w_in_range ? w_pos : '0;
                r_out_was    <= 1'b0;
            end else begin
                r_out_status <= w_in_range ? ST_OK : ST_OOR;
                r_out_index  <= r_idx;
                r_out_was    <= w_in_range ? w_word[w_bit] : 1'b0;
            end
        end
    end

    assign o_status       = r_out_status;
    assign o_result_index = r_out_index;
    assign o_was_used     = r_out_was;

`ifndef SYNTHESIS
    a_ok_below_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && !i_cfg_we |=> (r_out_status != ST_OK) || ({1'b0, r_out_index} < w_cap))
        else $error("successful result index at or above capacity");
    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && w_alloc && w_in_range |-> !w_word[w_bit])
        else $error("allocation picked a used entry");
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_full[$past(r_waddr)] == (&$past(w_new_word)))
        else $error("full summary out of step with written word");
`endif

endmodule

>>> src/bitmap_lowest_free_allocator.sv
// Channel | Dir | tdata (low bit up)               | tuser
// s_axis  | in  | index[11:0], zero pad to 16      | op[1:0]
// m_axis  | out | result_index[11:0], was_used[12] | status[1:0]
// cfg     | in  | entries_in_use[12:0]             | -
//
// Three steps per item: accept, word read, then execute and write back; the next
// item is accepted once the last is done. One memory read and one write per item;
// a per-word full summary picks the allocation word without scanning memory.
// Reset clears all word valid and full flags at once, bitmap reads all-free.
// A held result stalls the execute step until m_axis_tready.
module bitmap_lowest_free_allocator #(
    parameter int ENTRIES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // index[11:0], pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // result_index[11:0], was_used[12], pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import blfa_pkg::*;

    t_cmd              w_cmd;
    logic [IDX_W-1:0]  w_res_idx;
    logic              w_was;

    blfa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (w_cmd)
    );

    blfa_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (s_axis_tuser),
        .i_index        (s_axis_tdata[IDX_W-1:0]),
        .o_status       (m_axis_tuser),
        .o_result_index (w_res_idx),
        .o_was_used     (w_was)
    );

    assign m_axis_tdata = {3'b000, w_was, w_res_idx};

endmodule
